FILE: src/vrp_pkg.sv
// Package for the video register port with scroll: shared constants and codes.
// Used by every module in src; depends on nothing.
package vrp_pkg;

  // Video memory geometry and reset defaults.
  localparam int unsigned VRP_PAGES      = 16;
  localparam int unsigned VRP_PAGE_BYTES = 1024;
  localparam logic [63:0] VRP_BANK_RST   = 64'hFEDC_BA98_7654_3210;

  // Sprite attribute memory geometry.
  localparam int unsigned VRP_OAM_DEPTH = 256;
  localparam int unsigned VRP_OAM_AW    = 8;

  // Request type codes.
  localparam logic [2:0] REQ_RD_REG  = 3'd0;
  localparam logic [2:0] REQ_WR_REG  = 3'd1;
  localparam logic [2:0] REQ_VINC    = 3'd2;
  localparam logic [2:0] REQ_HCOPY   = 3'd3;
  localparam logic [2:0] REQ_VCOPY   = 3'd4;
  localparam logic [2:0] REQ_STATUS  = 3'd5;

  // Register select codes.
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STAT    = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // Start of palette space within the 14-bit video address.
  localparam logic [13:0] PAL_BASE   = 14'h3F00;
  localparam logic [13:0] PAL_UNDER  = 14'h1000;

endpackage

FILE: src/vrp_vram.sv
// Video memory of the register port: single write port, registered read port,
// and a zero-fill sweep after reset. Depends on vrp_pkg.
module vrp_vram
  import vrp_pkg::*;
#(
  parameter int unsigned DEPTH = VRP_PAGES * VRP_PAGE_BYTES,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata,
  output logic          ready
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] clr_addr_r;
  logic          clearing_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // The sweep owns the write port until every entry holds zero.
  always_comb begin
    wr_en   = clearing_r | we;
    wr_addr = clearing_r ? clr_addr_r : waddr;
    wr_data = clearing_r ? 8'h00 : wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
  assign ready = ~clearing_r;

endmodule

FILE: src/vrp_oam.sv
// Sprite attribute memory: 256 bytes with a registered read and per-entry valid
// bits so that unwritten entries read as zero right after reset. Depends on vrp_pkg.
module vrp_oam
  import vrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [VRP_OAM_AW-1:0] waddr,
  input  logic [7:0]            wdata,
  input  logic [VRP_OAM_AW-1:0] raddr,
  output logic [7:0]            rdata
);

  logic [7:0]               mem [VRP_OAM_DEPTH];
  logic [VRP_OAM_DEPTH-1:0] valid_r;
  logic [7:0]               rdata_r;
  logic                     rvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rvalid_r ? rdata_r : 8'h00;

endmodule

FILE: src/video_register_port_with_scroll_top.sv
// Top level of the video register port with scroll; instantiates vrp_vram and
// vrp_oam and depends on vrp_pkg.
// A request accepted while idle moves the state to ST_EXEC, and out_valid is
// registered from that state; no new request is accepted until the state has
// returned to ST_IDLE, so busy is high while a request is in progress.
// Reset (rst_n low at an edge) clears all registers but the request capture and
// zero-fills video memory; busy stays high after reset until the fill is done.
// The receiver cannot stall: each result is present for exactly one cycle.
module video_register_port_with_scroll_top
  import vrp_pkg::*;
#(
  parameter int unsigned PAGES = VRP_PAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_reg_select,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_vram_addr,
  output logic [2:0]  out_fine_x,
  output logic [7:0]  out_ctrl_value,
  output logic [7:0]  out_mask_value,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  localparam int unsigned DEPTH = PAGES * VRP_PAGE_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Wrapped page number for every possible bank nibble, built at elaboration.
  function automatic logic [63:0] wrap_pages();
    logic [63:0] tbl;
    begin
      tbl = '0;
      for (int i = 0; i < 16; i++) begin
        tbl[4*i +: 4] = 4'(i % PAGES);
      end
      wrap_pages = tbl;
    end
  endfunction

  localparam logic [63:0] PAGE_WRAP = wrap_pages();

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;

  // Architectural registers.
  logic [63:0] bank_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  oam_addr_r, oam_addr_nxt;
  logic [15:0] v_r, v_nxt;
  logic [14:0] t_r, t_nxt;
  logic [2:0]  fx_r, fx_nxt;
  logic        w_r, w_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic [7:0]  pal_r [32];

  // The request being worked on.
  logic [2:0]  req_r;
  logic [2:0]  sel_r;
  logic [7:0]  data_r;

  // Result registers.
  logic        out_valid_r;
  logic [7:0]  rd_r, rd_nxt;

  // Memory interface.
  logic          vid_we;
  logic [AW-1:0] vid_waddr;
  logic [AW-1:0] vid_raddr;
  logic [7:0]    vid_rdata;
  logic          vid_ready;
  logic          oam_we;
  logic [7:0]    oam_rdata;

  // Palette write decode.
  logic          pal_we;
  logic          pal_mirror;

  logic [13:0]   a14;
  logic          in_pal;
  logic [13:0]   rd_vaddr;
  logic          accept;

  // Map a 14-bit video address through the bank register to a physical index.
  // Page numbers not below PAGES wrap modulo PAGES.
  function automatic logic [AW-1:0] phys(input logic [63:0] bank,
                                         input logic [13:0] va);
    logic [3:0] nib;
    logic [3:0] page;
    logic [13:0] full;
    begin
      nib  = bank[{va[13:10], 2'b00} +: 4];
      page = PAGE_WRAP[{nib, 2'b00} +: 4];
      full = {page, va[9:0]};
      phys = full[AW-1:0];
    end
  endfunction

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // v is cut to 14 bits for memory access. Palette reads also refill the
  // buffer from the nametable byte that lies beneath the palette.
  assign a14      = v_r[13:0];
  assign in_pal   = (a14 >= PAL_BASE);
  assign rd_vaddr = in_pal ? (a14 - PAL_UNDER) : a14;

  // The read address is taken every cycle from the current state; the data
  // registered at the transfer edge belongs to the request then accepted.
  assign vid_raddr = phys(bank_r, rd_vaddr);
  assign vid_waddr = phys(bank_r, a14);

  vrp_vram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_vram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (vid_we),
    .waddr (vid_waddr),
    .wdata (data_r),
    .raddr (vid_raddr),
    .rdata (vid_rdata),
    .ready (vid_ready)
  );

  vrp_oam u_oam (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (oam_we),
    .waddr (oam_addr_r),
    .wdata (data_r),
    .raddr (oam_addr_r),
    .rdata (oam_rdata)
  );

  // Execute stage: all memory data for the request is now available, so the
  // whole register update and any write-back happen in this state.
  always_comb begin
    logic [15:0] vv;
    logic [4:0]  yy;
    state_nxt    = state_r;
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    oam_addr_nxt = oam_addr_r;
    v_nxt        = v_r;
    t_nxt        = t_r;
    fx_nxt       = fx_r;
    w_nxt        = w_r;
    rbuf_nxt     = rbuf_r;
    rd_nxt       = 8'h00;
    vid_we       = 1'b0;
    oam_we       = 1'b0;
    pal_we       = 1'b0;
    pal_mirror   = 1'b0;
    vv           = 16'h0000;
    yy           = 5'd0;

    case (state_r)
      ST_CLEAR: begin
        if (vid_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (req_r)
          REQ_RD_REG: begin
            case (sel_r)
              REG_STAT: begin
                rd_nxt     = status_r;
                status_nxt = {1'b0, status_r[6:0]};
                w_nxt      = 1'b0;
              end
              REG_OAMDATA: begin
                rd_nxt = oam_rdata;
              end
              REG_DATA: begin
                rd_nxt   = in_pal ? pal_r[a14[4:0]] : rbuf_r;
                rbuf_nxt = vid_rdata;
                v_nxt    = v_r + (ctrl_r[2] ? 16'd32 : 16'd1);
              end
              default: begin
              end
            endcase
          end
          REQ_WR_REG: begin
            case (sel_r)
              REG_CTRL: begin
                ctrl_nxt       = data_r;
                t_nxt[11:10]   = data_r[1:0];
              end
              REG_MASK: begin
                mask_nxt = data_r;
              end
              REG_OAMADDR: begin
                oam_addr_nxt = data_r;
              end
              REG_OAMDATA: begin
                oam_we       = 1'b1;
                oam_addr_nxt = oam_addr_r + 8'd1;
              end
              REG_SCROLL: begin
                if (w_r) begin
                  t_nxt[14:12] = data_r[2:0];
                  t_nxt[9:5]   = data_r[7:3];
                  w_nxt        = 1'b0;
                end else begin
                  t_nxt[4:0] = data_r[7:3];
                  fx_nxt     = data_r[2:0];
                  w_nxt      = 1'b1;
                end
              end
              REG_ADDR: begin
                if (w_r) begin
                  t_nxt[7:0] = data_r;
                  v_nxt      = {1'b0, t_r[14:8], data_r};
                  w_nxt      = 1'b0;
                end else begin
                  t_nxt[14:8] = {1'b0, data_r[5:0]};
                  w_nxt       = 1'b1;
                end
              end
              REG_DATA: begin
                if (in_pal) begin
                  pal_we     = 1'b1;
                  pal_mirror = (a14[1:0] == 2'b00);
                end else begin
                  vid_we = 1'b1;
                end
                v_nxt = v_r + (ctrl_r[2] ? 16'd32 : 16'd1);
              end
              default: begin
              end
            endcase
          end
          REQ_VINC: begin
            if (v_r[14:12] != 3'b111) begin
              v_nxt = v_r + 16'h1000;
            end else begin
              vv = v_r & 16'h8FFF;
              yy = vv[9:5];
              if (yy == 5'd29) begin
                yy = 5'd0;
                vv = vv ^ 16'h0800;
              end else if (yy == 5'd31) begin
                yy = 5'd0;
              end else begin
                yy = yy + 5'd1;
              end
              v_nxt = (vv & 16'hFC1F) | {6'd0, yy, 5'd0};
            end
          end
          REQ_HCOPY: begin
            v_nxt = (v_r & 16'hFBE0) | ({1'b0, t_r} & 16'h041F);
          end
          REQ_VCOPY: begin
            v_nxt = (v_r & 16'h841F) | ({1'b0, t_r} & 16'h7BE0);
          end
          REQ_STATUS: begin
            status_nxt = data_r;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, registers and the result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      bank_r      <= VRP_BANK_RST;
      ctrl_r      <= '0;
      mask_r      <= '0;
      status_r    <= '0;
      oam_addr_r  <= '0;
      v_r         <= '0;
      t_r         <= '0;
      fx_r        <= '0;
      w_r         <= 1'b0;
      rbuf_r      <= '0;
      out_valid_r <= 1'b0;
      rd_r        <= '0;
      for (int i = 0; i < 32; i++) begin
        pal_r[i] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      ctrl_r      <= ctrl_nxt;
      mask_r      <= mask_nxt;
      status_r    <= status_nxt;
      oam_addr_r  <= oam_addr_nxt;
      v_r         <= v_nxt;
      t_r         <= t_nxt;
      fx_r        <= fx_nxt;
      w_r         <= w_nxt;
      rbuf_r      <= rbuf_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      rd_r        <= rd_nxt;
      if (cfg_we) begin
        bank_r <= cfg_wdata;
      end
      // Palette entries that are multiples of four are shared between the
      // background and sprite halves, so such a write lands in both.
      if (pal_we) begin
        if (pal_mirror) begin
          pal_r[{1'b0, a14[3:0]}] <= data_r;
          pal_r[{1'b1, a14[3:0]}] <= data_r;
        end else begin
          pal_r[a14[4:0]] <= data_r;
        end
      end
    end
  end

  // Request capture; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      sel_r  <= in_reg_select;
      data_r <= in_write_data;
    end
  end

  // The other result fields follow the architectural registers, which hold
  // the values left by the request just finished while out_valid is high.
  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_r;
  assign out_vram_addr  = v_r;
  assign out_fine_x     = fx_r;
  assign out_ctrl_value = ctrl_r;
  assign out_mask_value = mask_r;

endmodule
